// File: hdl/fpba_pkg.sv
// Package for the fit policy block allocator: widths, codes and the structs
// that pass between the cells and the top level. No dependencies.
package fpba_pkg;

  localparam int ENTRIES   = 16;
  localparam int SIZE_BITS = 16;

  // Fixed field widths of the channels and registers
  localparam int FIELD_W     = 16;
  localparam int ENTRY_IDX_W = 4;
  localparam int CNT_W       = 5;
  localparam int MODE_W      = 2;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 5;

  localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int LDCMP_W    = (IDX_W > ENTRY_IDX_W) ? IDX_W : ENTRY_IDX_W;
  localparam int CNTCMP_W   = (IDX_W > CNT_W) ? IDX_W : CNT_W;

  // Commands
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_ALLOC = 1'b1;

  // Placement policies; the spare code behaves as first fit
  localparam logic [MODE_W-1:0] FIT_FIRST = 2'd0;
  localparam logic [MODE_W-1:0] FIT_BEST  = 2'd1;
  localparam logic [MODE_W-1:0] FIT_WORST = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FIT_MODE    = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  // Best candidate so far, handed from cell to cell
  typedef struct packed {
    logic                 have;
    logic [IDX_W-1:0]     pick;
    logic [SIZE_BITS-1:0] size;
    logic [SIZE_BITS-1:0] left;
  } cand_t;

  // Scan settings broadcast to every cell while a request runs
  typedef struct packed {
    logic [SIZE_BITS-1:0] req;
    logic [MODE_W-1:0]    mode;
    logic [CNT_W-1:0]     count;
  } scan_ctl_t;

  // Table updates broadcast to every cell
  typedef struct packed {
    logic                   ld_en;
    logic [ENTRY_IDX_W-1:0] ld_idx;
    logic [SIZE_BITS-1:0]   ld_size;
    logic                   mark_en;
    logic [IDX_W-1:0]       mark_idx;
  } upd_ctl_t;

endpackage

// File: hdl/fpba_if.sv
// Valid/ready channel interfaces for requests and results.
// Depends on fpba_pkg.
interface fpba_in_if;
  import fpba_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   command;
  logic [ENTRY_IDX_W-1:0] entry_index;
  logic [FIELD_W-1:0]     entry_size;
  logic [FIELD_W-1:0]     request_size;

  modport source (output valid, command, entry_index, entry_size, request_size,
                  input ready);
  modport sink   (input valid, command, entry_index, entry_size, request_size,
                  output ready);
endinterface

interface fpba_out_if;
  import fpba_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   found;
  logic [ENTRY_IDX_W-1:0] chosen_index;
  logic [FIELD_W-1:0]     chosen_size;
  logic [FIELD_W-1:0]     leftover;

  modport source (output valid, found, chosen_index, chosen_size, leftover,
                  input ready);
  modport sink   (input valid, found, chosen_index, chosen_size, leftover,
                  output ready);
endinterface

// File: hdl/fit_policy_block_allocator.sv
// Top level of the fit policy block allocator: control, registers and the
// chain of fpba_cell entries. Depends on fpba_pkg, fpba_if and fpba_cell.
//
//   channel   direction  handshake      carries
//   in_chan   sink       valid/ready    command, entry_index, entry_size, request_size
//   out_chan  source     valid/ready    found, chosen_index, chosen_size, leftover
//   cfg_*     input      cfg_we only    block_count (index 0), fit_mode (index 1)
//
// A load request gives no result. An allocate request runs a candidate down
// the chain of ENTRIES cells, one cell per cycle; once the token leaves the
// last cell the answer is committed to the output register. One request is
// in flight at a time.
// Reset (rst_n low at a clock edge) clears the used marks, both registers
// and all control; block sizes are unknown until loaded.
// A waiting result sits in the output register; loads are still taken, and
// a finished scan holds until that register is free.
module fit_policy_block_allocator (
  input  logic                            clk,
  input  logic                            rst_n,
  fpba_in_if.sink                         in_chan,
  fpba_out_if.source                      out_chan,
  input  logic                            cfg_we,
  input  logic [fpba_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fpba_pkg::CFG_DATA_W-1:0] cfg_data
);
  import fpba_pkg::*;

  // Configuration registers
  logic [CNT_W-1:0]     count_r;
  logic [MODE_W-1:0]    mode_r;

  // Control
  state_t               state_r;
  state_t               state_nxt;
  logic                 start_r;
  logic                 in_ready;
  logic                 commit;
  logic                 accept;
  logic                 alloc_acc;
  logic                 scan_done;
  logic                 out_free;

  // Request held for the whole scan
  logic [SIZE_BITS-1:0] req_r;

  // Output register
  logic                   out_valid_r;
  logic                   found_r;
  logic [ENTRY_IDX_W-1:0] chosen_index_r;
  logic [FIELD_W-1:0]     chosen_size_r;
  logic [FIELD_W-1:0]     leftover_r;

  // Chain wiring: element 0 feeds the first cell, the last is the answer
  cand_t                cand_w [ENTRIES+1];
  logic                 tok_w  [ENTRIES+1];
  scan_ctl_t            scan;
  upd_ctl_t             upd;

  assign accept    = in_chan.valid && in_ready;
  assign alloc_acc = accept && (in_chan.command == CMD_ALLOC);
  assign scan_done = tok_w[ENTRIES];
  assign out_free  = !out_valid_r || out_chan.ready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      mode_r  <= FIT_FIRST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BLOCK_COUNT: count_r <= cfg_data[CNT_W-1:0];
        REG_FIT_MODE:    mode_r  <= cfg_data[MODE_W-1:0];
      endcase
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (alloc_acc) state_nxt = ST_SCAN;
      ST_SCAN: if (scan_done) state_nxt = ST_DONE;
      ST_DONE: if (out_free)  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State outputs: take requests only when idle, commit once the answer lands
  always_comb begin
    in_ready = 1'b0;
    commit   = 1'b0;
    unique case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_SCAN: ;
      ST_DONE: commit   = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      start_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= alloc_acc;
    end
  end

  // Latch the request size when an allocate is taken
  always_ff @(posedge clk) begin
    if (alloc_acc) begin
      req_r <= SIZE_BITS'(in_chan.request_size);
    end
  end

  // Broadcasts to the cells
  always_comb begin
    scan.req   = req_r;
    scan.mode  = mode_r;
    scan.count = count_r;

    upd.ld_en    = accept && (in_chan.command == CMD_LOAD);
    upd.ld_idx   = in_chan.entry_index;
    upd.ld_size  = SIZE_BITS'(in_chan.entry_size);
    upd.mark_en  = commit && cand_w[ENTRIES].have;
    upd.mark_idx = cand_w[ENTRIES].pick;
  end

  // The candidate enters empty, so a miss reports all zeros
  assign cand_w[0] = '0;
  assign tok_w[0]  = start_r;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    fpba_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (IDX_W'(i)),
      .scan     (scan),
      .upd      (upd),
      .tok_in   (tok_w[i]),
      .cand_in  (cand_w[i]),
      .tok_out  (tok_w[i+1]),
      .cand_out (cand_w[i+1])
    );
  end

  // Output register: load on commit, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      found_r        <= cand_w[ENTRIES].have;
      chosen_index_r <= ENTRY_IDX_W'(cand_w[ENTRIES].pick);
      chosen_size_r  <= FIELD_W'(cand_w[ENTRIES].size);
      leftover_r     <= FIELD_W'(cand_w[ENTRIES].left);
    end
  end

  assign in_chan.ready         = in_ready;
  assign out_chan.valid        = out_valid_r;
  assign out_chan.found        = found_r;
  assign out_chan.chosen_index = chosen_index_r;
  assign out_chan.chosen_size  = chosen_size_r;
  assign out_chan.leftover     = leftover_r;

endmodule

// File: hdl/fpba_cell.sv
// One table entry of the allocator chain: holds a block size and its used
// mark, and improves the passing candidate. Depends on fpba_pkg.
module fpba_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [fpba_pkg::IDX_W-1:0] cell_idx,
  input  fpba_pkg::scan_ctl_t       scan,
  input  fpba_pkg::upd_ctl_t        upd,
  input  logic                      tok_in,
  input  fpba_pkg::cand_t           cand_in,
  output logic                      tok_out,
  output fpba_pkg::cand_t           cand_out
);
  import fpba_pkg::*;

  logic [SIZE_BITS-1:0] size_r;
  logic [SIZE_BITS-1:0] size_nxt;
  logic                 used_r;
  logic                 used_nxt;
  logic                 tok_r;
  cand_t                cand_r;
  cand_t                cand_nxt;

  logic                 in_range;
  logic                 ld_hit;
  logic                 mark_hit;
  logic                 eligible;
  logic                 take;
  logic [SIZE_BITS-1:0] left;

  always_comb begin
    in_range = CNTCMP_W'(cell_idx) < CNTCMP_W'(scan.count);
    ld_hit   = upd.ld_en && (LDCMP_W'(upd.ld_idx) == LDCMP_W'(cell_idx));
    mark_hit = upd.mark_en && (upd.mark_idx == cell_idx);
    left     = size_r - scan.req;
    eligible = in_range && !used_r && (size_r >= scan.req);

    // First fit keeps the earliest fit; best and worst replace on strict gain
    priority if (!eligible) begin
      take = 1'b0;
    end else if (!cand_in.have) begin
      take = 1'b1;
    end else if (scan.mode == FIT_BEST) begin
      take = left < cand_in.left;
    end else if (scan.mode == FIT_WORST) begin
      take = left > cand_in.left;
    end else begin
      take = 1'b0;
    end

    cand_nxt = cand_in;
    if (take) begin
      cand_nxt.have = 1'b1;
      cand_nxt.pick = cell_idx;
      cand_nxt.size = size_r;
      cand_nxt.left = left;
    end

    size_nxt = ld_hit ? upd.ld_size : size_r;
    priority if (ld_hit) begin
      used_nxt = 1'b0;
    end else if (mark_hit) begin
      used_nxt = 1'b1;
    end else begin
      used_nxt = used_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
      tok_r  <= 1'b0;
    end else begin
      used_r <= used_nxt;
      tok_r  <= tok_in;
    end
  end

  always_ff @(posedge clk) begin
    size_r <= size_nxt;
    if (tok_in) begin
      cand_r <= cand_nxt;
    end
  end

  assign tok_out  = tok_r;
  assign cand_out = cand_r;

endmodule
